// ===== rtl/tmu_pkg.sv =====
// shared types, constants and helpers for the margin update core
`timescale 1ns / 1ps
package tmu_pkg;

	localparam int IDX_W      = 12;
	localparam int WORD_W     = 16;
	localparam int SCORE_W    = 23;
	localparam int CFG_W      = 15;
	localparam int DIMS_W     = 7;
	localparam int ABS_W      = 17;
	localparam int ENTITIES_DEF  = 4096;
	localparam int RELATIONS_DEF = 1024;
	localparam int MAX_DIM_DEF   = 64;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 23'h7FFFFF;

	localparam logic [CFG_W-1:0]  MARGIN_RST = 15'd4096;
	localparam logic [CFG_W-1:0]  LR_RST     = 15'd4;
	localparam logic [DIMS_W-1:0] DIMS_RST   = 7'd50;

	typedef enum logic [1:0] {
		CFG_MARGIN = 2'd0,
		CFG_LR     = 2'd1,
		CFG_DIMS   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_TRAIN    = 2'd0,
		MODE_LOAD_ENT = 2'd1,
		MODE_LOAD_REL = 2'd2,
		MODE_READ_ENT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [11:0]        head_pos;
		logic [11:0]        tail_pos;
		logic [9:0]         relation_pos;
		logic [11:0]        head_neg;
		logic [11:0]        tail_neg;
		logic [9:0]         relation_neg;
		logic [5:0]         dim_index;
		logic signed [15:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic               updated;
		logic [22:0]        hinge_loss;
		logic [22:0]        score_pos;
		logic [22:0]        score_neg;
		logic signed [15:0] read_value;
	} out_item_t;

	function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] s;
		s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
		if (s > 17'sd32767) begin
			return 16'sh7FFF;
		end else if (s < -17'sd32768) begin
			return 16'sh8000;
		end
		return WORD_W'(s);
	endfunction

endpackage

// ===== rtl/tmu_alu.sv =====
// shared per-dimension unit: translation difference, magnitude, sign step and saturated relation and head updates
`timescale 1ns / 1ps
module tmu_alu (
	input  logic signed [tmu_pkg::WORD_W-1:0] t,
	input  logic signed [tmu_pkg::WORD_W-1:0] h,
	input  logic signed [tmu_pkg::WORD_W-1:0] r,
	input  logic [tmu_pkg::CFG_W-1:0]         lr,
	input  logic                              neg,
	output logic [tmu_pkg::ABS_W-1:0]         absd,
	output logic signed [tmu_pkg::WORD_W-1:0] step,
	output logic signed [tmu_pkg::WORD_W-1:0] new_r,
	output logic signed [tmu_pkg::WORD_W-1:0] new_h
);
	import tmu_pkg::*;

	logic signed [17:0]       diff;
	logic signed [WORD_W-1:0] lr_s;

	always_comb begin
		diff  = 18'(t) - 18'(h) - 18'(r);
		absd  = (diff < 0) ? ABS_W'(-diff) : ABS_W'(diff);
		lr_s  = {1'b0, lr};
		step  = ((diff > 0) ^ neg) ? lr_s : -lr_s;
		new_r = sat_add(r, step);
		new_h = sat_add(h, step);
	end

endmodule

// ===== rtl/transe_margin_update_core.sv =====
// top level: embedding tables, sequencer and result register
// usage
//  in channel (in_valid, in_stall, in_data) takes one item; in_stall is high while busy
//  out channel (out_valid, out_stall, out_data) gives one result per item
//  cfg_we/cfg_index/cfg_data write margin, learning rate, dims in use; the user
//  must write them only while idle, which the block itself does not enforce
//  every item first reduces its indices in S_REDUCE
//  load modes then pass S_EXEC and S_DONE; read mode passes S_EXEC, S_RDWAIT, S_DONE
//  train: S_SC_P and S_SC_N per dimension in use (both triples alternate on the table
//  read ports), S_SC_END, S_DECIDE, then, when the margin is violated, for each
//  dimension and each triple a read state and two write states on the entity port,
//  then S_DONE; the block returns to idle before the next item is taken
//  the finished result sits in an output register; the next item is taken
//  while it waits, and a later result waits in the sequencer until it is taken
//  reset clears control state and sets the settings to their defaults; table contents are undefined until loaded
`timescale 1ns / 1ps
module transe_margin_update_core #(
	parameter int ENTITIES  = tmu_pkg::ENTITIES_DEF,
	parameter int RELATIONS = tmu_pkg::RELATIONS_DEF,
	parameter int MAX_DIM   = tmu_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tmu_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tmu_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [tmu_pkg::CFG_W-1:0]  cfg_data
);
	import tmu_pkg::*;

	localparam int ER_W    = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
	localparam int RR_W    = (RELATIONS > 1) ? $clog2(RELATIONS) : 1;
	localparam int D_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DC_W    = $clog2(MAX_DIM + 1);
	localparam int E_DEPTH = ENTITIES * MAX_DIM;
	localparam int R_DEPTH = RELATIONS * MAX_DIM;
	localparam int EA_W    = (E_DEPTH > 1) ? $clog2(E_DEPTH) : 1;
	localparam int RA_W    = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
	localparam int SUM_W   = ABS_W + DC_W;
	localparam int LANES   = 7;
	localparam int KC_W    = $clog2(IDX_W);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_REDUCE = 12'b000000000010,
		S_EXEC   = 12'b000000000100,
		S_RDWAIT = 12'b000000001000,
		S_SC_P   = 12'b000000010000,
		S_SC_N   = 12'b000000100000,
		S_SC_END = 12'b000001000000,
		S_DECIDE = 12'b000010000000,
		S_U_RD   = 12'b000100000000,
		S_U_W1   = 12'b001000000000,
		S_U_W2   = 12'b010000000000,
		S_DONE   = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  margin_q, lr_q;
	logic [DIMS_W-1:0] dims_q;

	logic [LANES-1:0][IDX_W-1:0] lane_q;
	logic [KC_W-1:0]             k_q;
	mode_t                       mode_q;
	logic signed [WORD_W-1:0]    load_q;
	logic [DC_W-1:0]             d_q;
	logic                        neg_q;
	logic [SUM_W-1:0]            sum_pos_q, sum_neg_q;
	logic                        acc_s1, acc_neg_s1;
	out_item_t                   res_q;
	out_item_t                   out_q;
	logic                        out_valid_q;
	logic signed [WORD_W-1:0]    tcur_q, step_q;
	logic [EA_W-1:0]             tail_wa_q;

	logic signed [WORD_W-1:0] ent_mem [E_DEPTH];
	logic signed [WORD_W-1:0] rel_mem [R_DEPTH];
	logic signed [WORD_W-1:0] rd_t_q, rd_h_q, rd_r_q;

	logic [DC_W-1:0]  n_c;
	logic             sel_neg_c;
	logic [ER_W-1:0]  t_row_c, h_row_c;
	logic [RR_W-1:0]  r_row_c;
	logic [D_W-1:0]   dim_c, ldim_c;
	logic [EA_W-1:0]  ra_t_c, ra_h_c;
	logic [RA_W-1:0]  ra_r_c;
	logic             ent_we_c, rel_we_c;
	logic [EA_W-1:0]  ent_wa_c;
	logic [RA_W-1:0]  rel_wa_c;
	logic signed [WORD_W-1:0] ent_wd_c, rel_wd_c;
	logic             in_acc, out_acc, last_d_c;
	logic [ABS_W-1:0] absd_c;
	logic signed [WORD_W-1:0] step_c, new_r_c, new_h_c;
	logic [SCORE_W-1:0] sp_c, sn_c;
	logic [SCORE_W:0]   lhs_c, loss_c;
	logic               viol_c;
	logic               res_free_c;

	tmu_alu u_alu (
		.t     (rd_t_q),
		.h     (rd_h_q),
		.r     (rd_r_q),
		.lr    (lr_q),
		.neg   (neg_q),
		.absd  (absd_c),
		.step  (step_c),
		.new_r (new_r_c),
		.new_h (new_h_c)
	);

	assign in_acc     = in_valid && !in_stall;
	assign out_acc    = out_valid_q && !out_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign res_free_c = !out_valid_q || !out_stall;

	// address selection
	always_comb begin
		n_c       = (9'(dims_q) > 9'(MAX_DIM)) ? DC_W'(MAX_DIM) : DC_W'(dims_q);
		last_d_c  = ((d_q + 1'b1) == n_c);
		sel_neg_c = (state_q == S_SC_N) ||
			(neg_q && ((state_q == S_U_RD) || (state_q == S_U_W1)));
		t_row_c   = sel_neg_c ? ER_W'(lane_q[3]) : ER_W'(lane_q[1]);
		h_row_c   = sel_neg_c ? ER_W'(lane_q[2]) : ER_W'(lane_q[0]);
		r_row_c   = sel_neg_c ? RR_W'(lane_q[5]) : RR_W'(lane_q[4]);
		dim_c     = D_W'(d_q);
		ldim_c    = D_W'(lane_q[6]);
		if (state_q == S_EXEC) begin
			h_row_c = ER_W'(lane_q[0]);
			r_row_c = RR_W'(lane_q[4]);
			dim_c   = ldim_c;
		end
		ra_t_c = EA_W'(EA_W'(t_row_c) * EA_W'(MAX_DIM)) + EA_W'(dim_c);
		ra_h_c = EA_W'(EA_W'(h_row_c) * EA_W'(MAX_DIM)) + EA_W'(dim_c);
		ra_r_c = RA_W'(RA_W'(r_row_c) * RA_W'(MAX_DIM)) + RA_W'(dim_c);
	end

	// write port selection
	always_comb begin
		ent_we_c = 1'b0;
		rel_we_c = 1'b0;
		ent_wa_c = ra_h_c;
		rel_wa_c = ra_r_c;
		ent_wd_c = load_q;
		rel_wd_c = load_q;
		case (state_q)
			S_EXEC: begin
				ent_we_c = (mode_q == MODE_LOAD_ENT);
				rel_we_c = (mode_q == MODE_LOAD_REL);
			end
			S_U_W1: begin
				ent_we_c = 1'b1;
				rel_we_c = 1'b1;
				ent_wa_c = ra_h_c;
				ent_wd_c = new_h_c;
				rel_wd_c = new_r_c;
			end
			S_U_W2: begin
				ent_we_c = 1'b1;
				ent_wa_c = tail_wa_q;
				ent_wd_c = sat_add(tcur_q, -step_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we_c) begin
			ent_mem[ent_wa_c] <= ent_wd_c;
		end
		rd_t_q <= ent_mem[ra_t_c];
		rd_h_q <= ent_mem[ra_h_c];
	end

	always_ff @(posedge clk) begin
		if (rel_we_c) begin
			rel_mem[rel_wa_c] <= rel_wd_c;
		end
		rd_r_q <= rel_mem[ra_r_c];
	end

	// decision
	always_comb begin
		sp_c   = (sum_pos_q > SUM_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum_pos_q);
		sn_c   = (sum_neg_q > SUM_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum_neg_q);
		lhs_c  = (SCORE_W+1)'(sp_c) + (SCORE_W+1)'(margin_q);
		viol_c = lhs_c > (SCORE_W+1)'(sn_c);
		loss_c = lhs_c - (SCORE_W+1)'(sn_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
			lr_q     <= LR_RST;
			dims_q   <= DIMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MARGIN: margin_q <= cfg_data;
				CFG_LR:     lr_q     <= cfg_data;
				CFG_DIMS:   dims_q   <= DIMS_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			d_q         <= '0;
			neg_q       <= 1'b0;
			acc_s1      <= 1'b0;
			acc_neg_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_s1     <= (state_q == S_SC_P) || (state_q == S_SC_N);
			acc_neg_s1 <= (state_q == S_SC_N);
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_REDUCE;
						k_q     <= KC_W'(IDX_W - 1);
					end
				end
				S_REDUCE: begin
					if (k_q == '0) begin
						state_q <= (mode_q == MODE_TRAIN) ?
							((n_c == '0) ? S_DECIDE : S_SC_P) : S_EXEC;
						d_q     <= '0;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= (mode_q == MODE_READ_ENT) ? S_RDWAIT : S_DONE;
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_SC_P: begin
					state_q <= S_SC_N;
				end
				S_SC_N: begin
					if (last_d_c) begin
						state_q <= S_SC_END;
					end else begin
						state_q <= S_SC_P;
						d_q     <= d_q + 1'b1;
					end
				end
				S_SC_END: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					d_q   <= '0;
					neg_q <= 1'b0;
					state_q <= (viol_c && (n_c != '0)) ? S_U_RD : S_DONE;
				end
				S_U_RD: begin
					state_q <= S_U_W1;
				end
				S_U_W1: begin
					state_q <= S_U_W2;
				end
				S_U_W2: begin
					if (!neg_q) begin
						neg_q   <= 1'b1;
						state_q <= S_U_RD;
					end else begin
						neg_q <= 1'b0;
						if (last_d_c) begin
							state_q <= S_DONE;
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= S_U_RD;
						end
					end
				end
				S_DONE: begin
					if (res_free_c) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q    <= mode_t'(in_data.mode);
			load_q    <= in_data.load_value;
			lane_q[0] <= in_data.head_pos;
			lane_q[1] <= in_data.tail_pos;
			lane_q[2] <= in_data.head_neg;
			lane_q[3] <= in_data.tail_neg;
			lane_q[4] <= IDX_W'(in_data.relation_pos);
			lane_q[5] <= IDX_W'(in_data.relation_neg);
			lane_q[6] <= IDX_W'(in_data.dim_index);
			sum_pos_q <= '0;
			sum_neg_q <= '0;
			res_q     <= '0;
		end
		if (state_q == S_REDUCE) begin
			for (int i = 0; i < LANES; i++) begin
				if (32'(lane_q[i]) >= (32'(i < 4 ? ENTITIES : (i < 6 ? RELATIONS : MAX_DIM))
					<< k_q)) begin
					lane_q[i] <= IDX_W'(32'(lane_q[i]) -
						(32'(i < 4 ? ENTITIES : (i < 6 ? RELATIONS : MAX_DIM)) << k_q));
				end
			end
		end
		if (acc_s1) begin
			if (acc_neg_s1) begin
				sum_neg_q <= sum_neg_q + SUM_W'(absd_c);
			end else begin
				sum_pos_q <= sum_pos_q + SUM_W'(absd_c);
			end
		end
		// in read mode the head read port carries the entity word
		if (state_q == S_RDWAIT) begin
			res_q.read_value <= rd_h_q;
		end
		if (state_q == S_DECIDE) begin
			res_q.score_pos  <= sp_c;
			res_q.score_neg  <= sn_c;
			res_q.updated    <= viol_c;
			res_q.hinge_loss <= viol_c ?
				((loss_c > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(loss_c)) : '0;
		end
		if (state_q == S_U_W1) begin
			step_q    <= step_c;
			tail_wa_q <= ra_t_c;
			tcur_q    <= (ra_t_c == ra_h_c) ? new_h_c : rd_t_q;
		end
		if ((state_q == S_DONE) && res_free_c) begin
			out_q <= res_q;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("accepted item did not make the block busy");

	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.updated) |-> (out_data.read_value == 16'sd0))
		else $error("train result carries a read value");

	a_loss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.updated) |-> (out_data.hinge_loss == '0))
		else $error("loss reported without update");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && res_free_c) |=> out_valid)
		else $error("finished result not presented");

endmodule

// ===== verif/transe_margin_update_core_tb.sv =====
// self-checking testbench for the margin update core: table loads, reads and training items
`timescale 1ns / 1ps
module transe_margin_update_core_tb;
	import tmu_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int DIM_SLOTS = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	transe_margin_update_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mirror of the block
	logic signed [15:0] ent_mem [0:4096*DIM_SLOTS-1];
	logic signed [15:0] rel_mem [0:1024*DIM_SLOTS-1];
	int unsigned cur_margin = 4096;
	int unsigned cur_rate = 4;
	int unsigned cur_dims = 50;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int unsigned loaded_words[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int n_train = 0, n_update = 0, n_read = 0, n_load = 0, n_phase = 0;

	logic [11:0] ent_rows [4] = '{12'h000, 12'hFFF, 12'hA5A, 12'h5A5};
	logic [9:0] rel_rows [2] = '{10'h000, 10'h3FF};

	function automatic void queue_item(in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic int dims_used();
		return (cur_dims > DIM_SLOTS) ? DIM_SLOTS : cur_dims;
	endfunction

	function automatic int triple_diff(int h, int t, int r, int d);
		return int'(ent_mem[t*DIM_SLOTS+d]) - int'(ent_mem[h*DIM_SLOTS+d])
			- int'(rel_mem[r*DIM_SLOTS+d]);
	endfunction

	function automatic int unsigned l1_distance(int h, int t, int r);
		int unsigned sum;
		int x;
		sum = 0;
		for (int d = 0; d < dims_used(); d++) begin
			x = triple_diff(h, t, r, d);
			sum += (x < 0) ? -x : x;
		end
		return (sum > 8388607) ? 8388607 : sum;
	endfunction

	function automatic void step_triple(int h, int t, int r, int d, int s);
		rel_mem[r*DIM_SLOTS+d] = clamp16(int'(rel_mem[r*DIM_SLOTS+d]) + s);
		ent_mem[h*DIM_SLOTS+d] = clamp16(int'(ent_mem[h*DIM_SLOTS+d]) + s);
		ent_mem[t*DIM_SLOTS+d] = clamp16(int'(ent_mem[t*DIM_SLOTS+d]) - s);
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t r;
		int unsigned sp, sn, loss;
		int hp, tp, rp, hn, tn, rn, lr;
		r = '0;
		hp = it.head_pos; tp = it.tail_pos; rp = it.relation_pos;
		hn = it.head_neg; tn = it.tail_neg; rn = it.relation_neg;
		lr = cur_rate;
		case (mode_t'(it.mode))
			MODE_LOAD_ENT: begin
				ent_mem[hp*DIM_SLOTS+it.dim_index] = it.load_value;
				n_load++;
			end
			MODE_LOAD_REL: begin
				rel_mem[rp*DIM_SLOTS+it.dim_index] = it.load_value;
				n_load++;
			end
			MODE_READ_ENT: begin
				r.read_value = ent_mem[hp*DIM_SLOTS+it.dim_index];
				n_read++;
			end
			default: begin
				n_train++;
				sp = l1_distance(hp, tp, rp);
				sn = l1_distance(hn, tn, rn);
				r.score_pos = sp;
				r.score_neg = sn;
				if (sp + cur_margin > sn) begin
					n_update++;
					loss = sp + cur_margin - sn;
					r.updated = 1'b1;
					r.hinge_loss = (loss > 8388607) ? 8388607 : loss;
					for (int d = 0; d < dims_used(); d++) begin
						step_triple(hp, tp, rp, d, (triple_diff(hp, tp, rp, d) > 0) ? lr : -lr);
						step_triple(hn, tn, rn, d, (triple_diff(hn, tn, rn, d) > 0) ? -lr : lr);
					end
				end
			end
		endcase
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results = {expected_results, predict_result(in_data)};
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (out_data.updated !== exp_r.updated) begin
					$error("updated: expected %0d actual %0d", exp_r.updated, out_data.updated);
					errors++;
				end
				if (out_data.hinge_loss !== exp_r.hinge_loss) begin
					$error("hinge_loss: expected %0d actual %0d",
						exp_r.hinge_loss, out_data.hinge_loss);
					errors++;
				end
				if (out_data.score_pos !== exp_r.score_pos) begin
					$error("score_pos: expected %0d actual %0d", exp_r.score_pos, out_data.score_pos);
					errors++;
				end
				if (out_data.score_neg !== exp_r.score_neg) begin
					$error("score_neg: expected %0d actual %0d", exp_r.score_neg, out_data.score_neg);
					errors++;
				end
				if (out_data.read_value !== exp_r.read_value) begin
					$error("read_value: expected %0d actual %0d",
						exp_r.read_value, out_data.read_value);
					errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic in_item_t make_item(mode_t m, int unsigned hp, int unsigned tp,
		int unsigned rp, int unsigned hn, int unsigned tn, int unsigned rn, int unsigned di,
		int unsigned lv);
		in_item_t it;
		it.mode = m; it.head_pos = 12'(hp); it.tail_pos = 12'(tp);
		it.relation_pos = 10'(rp);
		it.head_neg = 12'(hn); it.tail_neg = 12'(tn); it.relation_neg = 10'(rn);
		it.dim_index = 6'(di); it.load_value = 16'(lv);
		if (m == MODE_LOAD_ENT) begin
			loaded_words = {loaded_words,
				int'(it.head_pos) * DIM_SLOTS + int'(it.dim_index)};
		end
		return it;
	endfunction

	function automatic logic signed [15:0] rand_word();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return $signed(16'($urandom_range(4000))) - 16'sd2000;
	endfunction

	function automatic logic [11:0] pick_ent();
		return ent_rows[$urandom_range(3)];
	endfunction

	function automatic logic [9:0] pick_rel();
		return rel_rows[$urandom_range(1)];
	endfunction

	function automatic in_item_t rand_train();
		logic [11:0] hp, tp, hn, tn;
		hp = pick_ent(); tp = pick_ent(); hn = pick_ent(); tn = pick_ent();
		if ($urandom_range(9) == 0) tn = hn;
		return make_item(MODE_TRAIN, hp, tp, pick_rel(), hn, tn, pick_rel(),
			$urandom, $urandom);
	endfunction

	function automatic in_item_t rand_item();
		int unsigned sel, a;
		sel = $urandom_range(99);
		if (sel < 55) return rand_train();
		if (sel < 68) return make_item(MODE_LOAD_ENT, pick_ent(), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, rand_word());
		if (sel < 78) return make_item(MODE_LOAD_REL, $urandom, $urandom, pick_rel(),
			$urandom, $urandom, $urandom, $urandom, rand_word());
		if (sel < 90) begin
			a = loaded_words[$urandom_range(loaded_words.size()-1)];
			return make_item(MODE_READ_ENT, a / DIM_SLOTS, $urandom, $urandom,
				$urandom, $urandom, $urandom, a % DIM_SLOTS, $urandom);
		end
		// load into random entity rows, mostly outside the training set
		return make_item(MODE_LOAD_ENT, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MARGIN: cur_margin = val;
			CFG_LR:     cur_rate = val;
			CFG_DIMS:   cur_dims = val[DIMS_W-1:0];
			default:    ;
		endcase
	endtask

	task automatic run_phase(int m, int lr, int dm, int sidle, int rstall, int count);
		wait_drained();
		write_reg(CFG_MARGIN, CFG_W'(m));
		write_reg(CFG_LR, CFG_W'(lr));
		write_reg(CFG_DIMS, CFG_W'(dm));
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		n_phase++;
		for (int i = 0; i < count; i++) begin
			queue_item(rand_item());
			// in the second phase, stop queueing halfway until all results are in
			if (i == count / 2 && n_phase == 2) begin
				while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
					@(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// fill every word of the training rows
		foreach (ent_rows[i])
			for (int d = 0; d < DIM_SLOTS; d++)
				queue_item(make_item(MODE_LOAD_ENT, ent_rows[i], $urandom,
					$urandom, $urandom, $urandom, $urandom, d, rand_word()));
		foreach (rel_rows[i])
			for (int d = 0; d < DIM_SLOTS; d++)
				queue_item(make_item(MODE_LOAD_REL, $urandom, $urandom,
					rel_rows[i], $urandom, $urandom, $urandom, d, rand_word()));

		// directed items at reset settings
		queue_item(make_item(MODE_LOAD_ENT, 12'hFFF, 0, 0, 0, 0, 0, 6'd63, 16'sh7FFF));
		queue_item(make_item(MODE_LOAD_ENT, 12'h000, 0, 0, 0, 0, 0, 6'd0, 16'sh8000));
		queue_item(make_item(MODE_LOAD_REL, 0, 0, 10'h3FF, 0, 0, 0, 6'd63, 16'sh8000));
		queue_item(make_item(MODE_LOAD_REL, 0, 0, 10'h000, 0, 0, 0, 6'd0, 16'sh7FFF));
		queue_item(make_item(MODE_READ_ENT, 12'hFFF, 0, 0, 0, 0, 0, 6'd63, 0));
		queue_item(make_item(MODE_READ_ENT, 12'h000, 12'hFFF, 10'h3FF, 12'hFFF,
			12'hFFF, 10'h3FF, 6'd0, 16'shFFFF));
		// identical triples: equal scores, margin decides
		queue_item(make_item(MODE_TRAIN, 12'hA5A, 12'h5A5, 10'h3FF, 12'hA5A,
			12'h5A5, 10'h3FF, 6'd0, 0));
		// head equal to tail
		queue_item(make_item(MODE_TRAIN, 12'hFFF, 12'hFFF, 10'h000, 12'h000,
			12'hA5A, 10'h3FF, 6'd0, 0));
		// rows shared between the two triples
		queue_item(make_item(MODE_TRAIN, 12'h000, 12'hFFF, 10'h000, 12'hFFF,
			12'h000, 10'h000, 6'd0, 0));
		queue_item(make_item(MODE_TRAIN, 12'h5A5, 12'h000, 10'h3FF, 12'h5A5,
			12'hFFF, 10'h3FF, 6'd0, 0));
		queue_item(make_item(MODE_READ_ENT, 12'hFFF, 0, 0, 0, 0, 0, 6'd0, 0));
		queue_item(make_item(MODE_READ_ENT, 12'h5A5, 0, 0, 0, 0, 0, 6'd49, 0));
		queue_item(make_item(MODE_READ_ENT, 12'h5A5, 0, 0, 0, 0, 0, 6'd50, 0));
		for (int i = 0; i < 6; i++) queue_item(rand_train());

		// the spare index must leave the settings alone
		wait_drained();
		write_reg(CFG_SPARE, 15'h7FFF);
		queue_item(rand_train());

		run_phase(32767, 32767, 64, 0, 0, 21);
		run_phase(0, 0, 1, 71, 0, 21);
		run_phase($urandom_range(32767), $urandom_range(64), 0, 0, 71, 21);
		run_phase($urandom_range(8192), $urandom_range(200), 127, 30, 30, 21);
		run_phase(4096, 4, 64, 0, 0, 21);
		run_phase($urandom_range(32767), $urandom_range(32767), $urandom_range(1, 64),
			71, 71, 21);
		run_phase($urandom_range(16384), 16, $urandom_range(1, 63), 30, 30, 21);
		wait_drained();

		$display("covered %0d loads, %0d reads, %0d training items (%0d with updates)",
			n_load, n_read, n_train, n_update);
		$display("over %0d setting changes including zero and saturating dimension counts",
			n_phase);
		if (errors == 0) begin
			$display("** transe_margin_update_core: PASSED **");
		end else begin
			$display("** transe_margin_update_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("** transe_margin_update_core: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tmu_pkg.sv
rtl/tmu_alu.sv
rtl/transe_margin_update_core.sv
verif/transe_margin_update_core_tb.sv
